// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define FFHA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: rtl/ffha_pkg.sv
package ffha_pkg;

  // default sizing
  localparam int unsigned FREE_SLOTS_DEF   = 32;
  localparam int unsigned USED_SLOTS_DEF   = 32;
  localparam int unsigned OFFSET_BITS_DEF  = 16;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  // fixed field widths
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // split threshold beyond the header, and request rounding
  localparam int unsigned MIN_FREE    = 8;
  localparam int unsigned ALIGN_BYTES = 4;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 16'hFFFF;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // operations
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'd1;

endpackage

// File: rtl/first_fit_heap_allocator.sv
// channel   | direction | signals
// ----------+-----------+-----------------------------------------------------
// in        | sink      | in_valid_i/in_ready_o, func_i, request_bytes_i, address_i
// out       | source    | out_valid_o/out_ready_i, status_o, result_address_o,
//           |           | granted_bytes_o
// cfg       | sink      | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i
//
// allocate: scans the free table for the first segment that fits, else reports out of memory;
//   a zero request or an empty table goes straight to the result; a whole take shifts entries down
// free: scans the used table for the pointer (bad free when absent), then the free table for its
//   place, then merges, shifts entries, inserts and hands off the result
// one transaction at a time, with an idle state between them; reset and register writes pass through
//   an init state that writes the first free segment; a second finished result stalls for out_ready_i

`include "assert_macros.svh"

module first_fit_heap_allocator #(
  parameter int unsigned FREE_SLOTS   = ffha_pkg::FREE_SLOTS_DEF,
  parameter int unsigned USED_SLOTS   = ffha_pkg::USED_SLOTS_DEF,
  parameter int unsigned OFFSET_BITS  = ffha_pkg::OFFSET_BITS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [ffha_pkg::BYTES_W-1:0]   request_bytes_i,
  input  logic [ffha_pkg::ADDR_W-1:0]    address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  output logic [ffha_pkg::ADDR_W-1:0]    result_address_o,
  output logic [ffha_pkg::BYTES_W-1:0]   granted_bytes_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffha_pkg::ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned OW  = OFFSET_BITS;
  localparam int unsigned BW  = ffha_pkg::BYTES_W;
  localparam int unsigned DW  = OW + BW;
  localparam int unsigned FIW = $clog2(FREE_SLOTS);
  localparam int unsigned FCW = $clog2(FREE_SLOTS + 1);
  localparam int unsigned UIW = $clog2(USED_SLOTS);
  localparam int unsigned UCW = $clog2(USED_SLOTS + 1);
  localparam logic [31:0] HDR  = 32'(HEADER_BYTES);
  localparam logic [31:0] MINF = 32'(ffha_pkg::MIN_FREE);
  localparam logic [16:0] RND  = 17'(ffha_pkg::ALIGN_BYTES - 1);

  // sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_ADEC  = 4'd3;
  localparam logic [3:0] S_USCAN = 4'd4;
  localparam logic [3:0] S_FSCAN = 4'd5;
  localparam logic [3:0] S_FDEC  = 4'd6;
  localparam logic [3:0] S_SHL   = 4'd7;
  localparam logic [3:0] S_SHR   = 4'd8;
  localparam logic [3:0] S_INSW  = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [31:0]           base_q, base_d;
  logic [15:0]           size_q, size_d;
  logic [FCW-1:0]        fcnt_q, fcnt_d;
  logic [USED_SLOTS-1:0] valid_q, valid_d;
  logic                  pend_q, pend_d;
  logic                  ov_q, ov_d;

  logic [16:0]   n_q, n_d;
  logic [31:0]   off_q, off_d;
  logic [FCW-1:0] idx_q, idx_d, ridx_q, ridx_d, rem_q, rem_d, pos_q, pos_d;
  logic [DW-1:0] ent_q, ent_d, prv_q, prv_d;
  logic          hasr_q, hasr_d;
  logic [UCW-1:0] uidx_q, uidx_d;
  logic [UIW-1:0] uridx_q, uridx_d, slot_q, slot_d;
  logic [BW-1:0] ubytes_q, ubytes_d;
  logic [ffha_pkg::STATUS_W-1:0] res_st_q, res_st_d, out_st_q;
  logic [31:0]   res_addr_q, res_addr_d, out_addr_q;
  logic [BW-1:0] res_bytes_q, res_bytes_d, out_bytes_q;

  // memory ports
  logic           f_we, u_we;
  logic [FIW-1:0] f_waddr, f_raddr;
  logic [UIW-1:0] u_waddr, u_raddr;
  logic [DW-1:0]  f_wdata, f_rdata, u_wdata, u_rdata;

  logic           out_free;
  logic [UIW-1:0] fslot;
  logic           fslot_ok;

  ffha_ram #(.DEPTH(FREE_SLOTS), .DW(DW)) u_free_mem (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  ffha_ram #(.DEPTH(USED_SLOTS), .DW(DW)) u_used_mem (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  // lowest free used-table slot
  always_comb begin
    fslot    = '0;
    fslot_ok = 1'b0;
    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        fslot    = UIW'(i);
        fslot_ok = 1'b1;
      end
    end
  end

  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // sequencer
  always_comb begin
    logic [31:0]    fr_start, fr_bytes, ur_start;
    logic [31:0]    e_start, e_bytes, p_start, p_bytes, ub;
    logic [31:0]    a_hdr32, rb32;
    logic [OW-1:0]  a_hdr;
    logic [BW-1:0]  a_grant, rb;
    logic [FCW-1:0] rm1, rp1, pm1;
    logic           right, left;

    fr_start = 32'(f_rdata[DW-1:BW]);
    fr_bytes = 32'(f_rdata[BW-1:0]);
    ur_start = 32'(u_rdata[DW-1:BW]);
    e_start  = 32'(ent_q[DW-1:BW]);
    e_bytes  = 32'(ent_q[BW-1:0]);
    p_start  = 32'(prv_q[DW-1:BW]);
    p_bytes  = 32'(prv_q[BW-1:0]);
    ub       = 32'(ubytes_q);
    rm1      = ridx_q - FCW'(1);
    rp1      = ridx_q + FCW'(1);
    pm1      = pos_q - FCW'(1);
    a_hdr32  = e_start + e_bytes - 32'(n_q);
    a_hdr    = OW'(a_hdr32);
    a_grant  = BW'(n_q);
    rb32     = e_bytes + ub + HDR;
    rb       = BW'(rb32);
    right    = hasr_q && ((off_q + HDR + ub) == e_start);
    left     = (pos_q != '0) && ((p_start + HDR + p_bytes) == off_q);

    state_d     = state_q;
    base_d      = base_q;
    size_d      = size_q;
    fcnt_d      = fcnt_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    n_d         = n_q;
    off_d       = off_q;
    idx_d       = idx_q;
    ridx_d      = ridx_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    ent_d       = ent_q;
    prv_d       = prv_q;
    hasr_d      = hasr_q;
    uidx_d      = uidx_q;
    uridx_d     = uridx_q;
    slot_d      = slot_q;
    ubytes_d    = ubytes_q;
    res_st_d    = res_st_q;
    res_addr_d  = res_addr_q;
    res_bytes_d = res_bytes_q;

    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    f_raddr = idx_q[FIW-1:0];
    u_we    = 1'b0;
    u_waddr = fslot;
    u_wdata = '0;
    u_raddr = uidx_q[UIW-1:0];

    case (state_q)
      // lay down the single initial segment
      S_INIT: begin
        if (32'(size_q) > 2 * HDR + MINF) begin
          f_we    = 1'b1;
          f_wdata = {OW'(HDR), BW'(32'(size_q) - 2 * HDR)};
          fcnt_d  = FCW'(1);
        end else begin
          fcnt_d  = '0;
        end
        valid_d = '0;
        state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid_i) begin
          idx_d      = '0;
          uidx_d     = '0;
          pend_d     = 1'b0;
          res_addr_d = '0;
          res_bytes_d = '0;
          n_d        = (17'(request_bytes_i) + RND) & ~RND;
          off_d      = address_i - base_q - HDR;
          if (func_i == ffha_pkg::FUNC_FREE) begin
            state_d = S_USCAN;
          end else if (request_bytes_i == '0) begin
            res_st_d = ffha_pkg::ST_ZERO;
            state_d  = S_RESP;
          end else if (fcnt_q == '0) begin
            res_st_d = ffha_pkg::ST_OOM;
            state_d  = S_RESP;
          end else begin
            state_d = S_ASCAN;
          end
        end
      end

      // first fit search, one entry read per cycle
      S_ASCAN: begin
        if (pend_q && (32'(fr_bytes) >= 32'(n_q))) begin
          ent_d   = f_rdata;
          pos_d   = ridx_q;
          state_d = S_ADEC;
        end else if (idx_q == fcnt_q) begin
          res_st_d = ffha_pkg::ST_OOM;
          state_d  = S_RESP;
        end else begin
          ridx_d = idx_q;
          idx_d  = idx_q + FCW'(1);
          pend_d = 1'b1;
        end
      end

      // split the segment or take it whole
      S_ADEC: begin
        pend_d = 1'b0;
        if (!fslot_ok) begin
          res_st_d = ffha_pkg::ST_FULL;
          state_d  = S_RESP;
        end else begin
          u_we           = 1'b1;
          valid_d[fslot] = 1'b1;
          res_st_d       = ffha_pkg::ST_OK;
          if (e_bytes >= 32'(n_q) + HDR + MINF) begin
            f_we        = 1'b1;
            f_waddr     = pos_q[FIW-1:0];
            f_wdata     = {ent_q[DW-1:BW], BW'(e_bytes - 32'(n_q) - HDR)};
            u_wdata     = {a_hdr, a_grant};
            res_addr_d  = base_q + 32'(a_hdr) + HDR;
            res_bytes_d = a_grant;
            state_d     = S_RESP;
          end else begin
            u_wdata     = ent_q;
            res_addr_d  = base_q + e_start + HDR;
            res_bytes_d = ent_q[BW-1:0];
            rem_d       = fcnt_q - pos_q - FCW'(1);
            idx_d       = pos_q + FCW'(1);
            if (fcnt_q - pos_q - FCW'(1) != '0) begin
              state_d = S_SHL;
            end else begin
              fcnt_d  = fcnt_q - FCW'(1);
              state_d = S_RESP;
            end
          end
        end
      end

      // look up the pointer among live blocks
      S_USCAN: begin
        if (pend_q && valid_q[uridx_q] && (ur_start == off_q)) begin
          slot_d   = uridx_q;
          ubytes_d = u_rdata[BW-1:0];
          idx_d    = '0;
          pend_d   = 1'b0;
          if (fcnt_q == '0) begin
            pos_d   = '0;
            hasr_d  = 1'b0;
            state_d = S_FDEC;
          end else begin
            state_d = S_FSCAN;
          end
        end else if (uidx_q == UCW'(USED_SLOTS)) begin
          res_st_d = ffha_pkg::ST_BADFREE;
          state_d  = S_RESP;
        end else begin
          uridx_d = uidx_q[UIW-1:0];
          uidx_d  = uidx_q + UCW'(1);
          pend_d  = 1'b1;
        end
      end

      // find the insert point, keep the left neighbour
      S_FSCAN: begin
        if (pend_q && (fr_start > off_q)) begin
          pos_d   = ridx_q;
          ent_d   = f_rdata;
          hasr_d  = 1'b1;
          state_d = S_FDEC;
        end else begin
          if (pend_q) begin
            prv_d = f_rdata;
          end
          if (idx_q == fcnt_q) begin
            pos_d   = fcnt_q;
            hasr_d  = 1'b0;
            state_d = S_FDEC;
          end else begin
            ridx_d = idx_q;
            idx_d  = idx_q + FCW'(1);
            pend_d = 1'b1;
          end
        end
      end

      // coalesce or insert
      S_FDEC: begin
        pend_d      = 1'b0;
        res_st_d    = ffha_pkg::ST_OK;
        res_bytes_d = ubytes_q;
        if (right && left) begin
          f_we           = 1'b1;
          f_waddr        = pm1[FIW-1:0];
          f_wdata        = {prv_q[DW-1:BW], BW'(p_bytes + 32'(rb) + HDR)};
          valid_d[slot_q] = 1'b0;
          rem_d          = fcnt_q - pos_q - FCW'(1);
          idx_d          = pos_q + FCW'(1);
          if (fcnt_q - pos_q - FCW'(1) != '0) begin
            state_d = S_SHL;
          end else begin
            fcnt_d  = fcnt_q - FCW'(1);
            state_d = S_RESP;
          end
        end else if (right) begin
          f_we           = 1'b1;
          f_waddr        = pos_q[FIW-1:0];
          f_wdata        = {OW'(off_q), rb};
          valid_d[slot_q] = 1'b0;
          state_d        = S_RESP;
        end else if (left) begin
          f_we           = 1'b1;
          f_waddr        = pm1[FIW-1:0];
          f_wdata        = {prv_q[DW-1:BW], BW'(p_bytes + ub + HDR)};
          valid_d[slot_q] = 1'b0;
          state_d        = S_RESP;
        end else if (fcnt_q == FCW'(FREE_SLOTS)) begin
          res_st_d    = ffha_pkg::ST_FULL;
          res_bytes_d = '0;
          state_d     = S_RESP;
        end else if (pos_q < fcnt_q) begin
          idx_d   = fcnt_q - FCW'(1);
          rem_d   = fcnt_q - pos_q;
          state_d = S_SHR;
        end else begin
          state_d = S_INSW;
        end
      end

      // close the gap: read k+1, write k
      S_SHL: begin
        if (pend_q) begin
          f_we    = 1'b1;
          f_waddr = rm1[FIW-1:0];
          f_wdata = f_rdata;
        end
        if (rem_q != '0) begin
          ridx_d = idx_q;
          idx_d  = idx_q + FCW'(1);
          rem_d  = rem_q - FCW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            fcnt_d  = fcnt_q - FCW'(1);
            state_d = S_RESP;
          end
        end
      end

      // open a gap: read k-1, write k, walking down
      S_SHR: begin
        if (pend_q) begin
          f_we    = 1'b1;
          f_waddr = rp1[FIW-1:0];
          f_wdata = f_rdata;
        end
        if (rem_q != '0) begin
          ridx_d = idx_q;
          idx_d  = idx_q - FCW'(1);
          rem_d  = rem_q - FCW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_INSW;
          end
        end
      end

      S_INSW: begin
        f_we            = 1'b1;
        f_waddr         = pos_q[FIW-1:0];
        f_wdata         = {OW'(off_q), ubytes_q};
        fcnt_d          = fcnt_q + FCW'(1);
        valid_d[slot_q] = 1'b0;
        state_d         = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_INIT;
      end
    endcase

    // register writes restart the heap
    if (cfg_valid_i) begin
      if (cfg_index_i == ffha_pkg::CFG_HEAP_BASE) begin
        base_d  = cfg_data_i;
        state_d = S_INIT;
      end else if (cfg_index_i == ffha_pkg::CFG_HEAP_SIZE) begin
        size_d  = cfg_data_i[15:0];
        state_d = S_INIT;
      end
    end
  end

  // output slot occupancy
  always_comb begin
    if ((state_q == S_RESP) && out_free) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      base_q  <= '0;
      size_q  <= ffha_pkg::HEAP_SIZE_RST;
      fcnt_q  <= '0;
      valid_q <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      size_q  <= size_d;
      fcnt_q  <= fcnt_d;
      valid_q <= valid_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    off_q       <= off_d;
    idx_q       <= idx_d;
    ridx_q      <= ridx_d;
    rem_q       <= rem_d;
    pos_q       <= pos_d;
    ent_q       <= ent_d;
    prv_q       <= prv_d;
    hasr_q      <= hasr_d;
    uidx_q      <= uidx_d;
    uridx_q     <= uridx_d;
    slot_q      <= slot_d;
    ubytes_q    <= ubytes_d;
    res_st_q    <= res_st_d;
    res_addr_q  <= res_addr_d;
    res_bytes_q <= res_bytes_d;
    if ((state_q == S_RESP) && out_free) begin
      out_st_q    <= res_st_q;
      out_addr_q  <= res_addr_q;
      out_bytes_q <= res_bytes_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = out_st_q;
  assign result_address_o = out_addr_q;
  assign granted_bytes_o  = out_bytes_q;

  // checks
  `FFHA_ASSERT_NR(a_fcnt_range, !rst_ni || (fcnt_q <= FCW'(FREE_SLOTS)), "free count beyond table")
  `FFHA_ASSERT(a_shl_nonempty, (state_q == S_SHL) |-> (fcnt_q != '0), "shift on empty table")
  `FFHA_ASSERT(a_out_from_resp, $rose(ov_q) |-> $past(state_q == S_RESP), "result without finish")

endmodule

// File: rtl/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned DW    = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
